[rtl/hsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared widths, defaults and the hue ramp segment codes of the HSL to RGB
// converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int IN_W              = 16;
    localparam int OUT_W             = 8;
    localparam int FRACTION_BITS_DEF = 15;

    typedef enum logic [1:0] {
        ARM_RISE,
        ARM_HIGH,
        ARM_FALL,
        ARM_LOW
    } arm_t;

endpackage

[rtl/hsl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_front
// First stage: clamp saturation and lightness, form the lightness by
// saturation product and the wrapped hue positions of the three channels.
// ----------------------------------------------------------------------------
module hsl_front #(
    parameter int FB = 15
) (
    input  logic                       aclk,
    input  logic                       adv,
    input  logic [hsl_pkg::IN_W-1:0]   hue,
    input  logic [hsl_pkg::IN_W-1:0]   saturation,
    input  logic [hsl_pkg::IN_W-1:0]   lightness,
    output logic [FB:0]                l_q,
    output logic [FB:0]                s_q,
    output logic [2*FB+1:0]            prod_q,
    output logic [FB+2:0]              t_r_q,
    output logic [FB+2:0]              t_g_q,
    output logic [FB+2:0]              t_b_q
);
    import hsl_pkg::*;

    localparam int HW  = (FB < IN_W) ? FB : IN_W;
    localparam int VW  = FB + 1;
    localparam int CW  = (VW > IN_W) ? VW : IN_W;
    localparam int PW  = 2 * VW;
    localparam int TW  = FB + 3;
    localparam int TW1 = TW + 1;

    localparam logic [CW-1:0]  ONE_C  = CW'(1) << FB;
    localparam logic [TW1-1:0] TWO_T  = TW1'(2) << FB;
    localparam logic [TW1-1:0] FOUR_T = TW1'(4) << FB;
    localparam logic [TW1-1:0] SIX_T  = TW1'(6) << FB;

    logic [HW-1:0]  h;
    logic [CW-1:0]  s_ext;
    logic [CW-1:0]  l_ext;
    logic [VW-1:0]  s_c;
    logic [VW-1:0]  l_c;
    logic [TW1-1:0] h_ext;
    logic [TW1-1:0] t6;
    logic [TW1-1:0] t_r_w;
    logic [TW1-1:0] t_b_w;

    logic [VW-1:0]  l_reg;
    logic [VW-1:0]  s_reg;
    logic [PW-1:0]  prod_reg;
    logic [TW-1:0]  t_r_reg;
    logic [TW-1:0]  t_g_reg;
    logic [TW-1:0]  t_b_reg;

    always_comb begin
        h     = hue[HW-1:0];
        s_ext = CW'(saturation);
        l_ext = CW'(lightness);
        s_c   = (s_ext > ONE_C) ? ONE_C[VW-1:0] : s_ext[VW-1:0];
        l_c   = (l_ext > ONE_C) ? ONE_C[VW-1:0] : l_ext[VW-1:0];
        h_ext = TW1'(h);
        t6    = (h_ext << 2) + (h_ext << 1);
        t_r_w = t6 + TWO_T;
        if (t_r_w >= SIX_T) begin
            t_r_w = t_r_w - SIX_T;
        end
        t_b_w = t6 + FOUR_T;
        if (t_b_w >= SIX_T) begin
            t_b_w = t_b_w - SIX_T;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l_reg    <= l_c;
            s_reg    <= s_c;
            prod_reg <= PW'(l_c) * PW'(s_c);
            t_r_reg  <= t_r_w[TW-1:0];
            t_g_reg  <= t6[TW-1:0];
            t_b_reg  <= t_b_w[TW-1:0];
        end
    end

    assign l_q    = l_reg;
    assign s_q    = s_reg;
    assign prod_q = prod_reg;
    assign t_r_q  = t_r_reg;
    assign t_g_q  = t_g_reg;
    assign t_b_q  = t_b_reg;

endmodule

[rtl/hsl_pq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pq
// Second stage: form q, p and the ramp slope q - p from lightness,
// saturation and their product.
// ----------------------------------------------------------------------------
module hsl_pq #(
    parameter int FB = 15
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            vld,
    input  logic [FB:0]     l,
    input  logic [FB:0]     s,
    input  logic [2*FB+1:0] prod,
    output logic [FB:0]     p_q,
    output logic [FB:0]     q_q,
    output logic [FB:0]     d_q
);
    import hsl_pkg::*;

    localparam int VW  = FB + 1;
    localparam int VW1 = VW + 1;

    localparam logic [VW-1:0] ONE_C  = VW'(1) << FB;
    localparam logic [VW-1:0] HALF_C = VW'(1) << (FB - 1);

    logic [VW-1:0]  m;
    logic [VW1-1:0] q_w;
    logic [VW-1:0]  q_c;
    logic [VW-1:0]  p_c;

    logic [VW-1:0]  p_reg;
    logic [VW-1:0]  q_reg;
    logic [VW-1:0]  d_reg;

    always_comb begin
        m = prod[FB +: VW];
        if (l < HALF_C) begin
            q_w = VW1'(l) + VW1'(m);
        end else begin
            q_w = VW1'(l) + VW1'(s) - VW1'(m);
        end
        q_c = q_w[VW-1:0];
        p_c = VW'((VW1'(l) << 1) - VW1'(q_c));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg <= p_c;
            q_reg <= q_c;
            d_reg <= q_c - p_c;
        end
    end

    assign p_q = p_reg;
    assign q_q = q_reg;
    assign d_q = d_reg;

    a_pq_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vld |-> (p_reg <= q_reg) && (q_reg <= ONE_C))
        else $error("q/p out of order");

endmodule

[rtl/hsl_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_chan
// One color channel: select the hue ramp segment, multiply the slope by the
// ramp position, add the base level, then scale by 255 and clamp.
// ----------------------------------------------------------------------------
module hsl_chan #(
    parameter int FB = 15
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [FB+2:0]             t,
    input  logic [FB:0]               p,
    input  logic [FB:0]               q,
    input  logic [FB:0]               d,
    output logic [hsl_pkg::OUT_W-1:0] level_q
);
    import hsl_pkg::*;

    localparam int VW  = FB + 1;
    localparam int XW  = FB + 1;
    localparam int TW  = FB + 3;
    localparam int PW  = VW + XW;
    localparam int SW  = PW + 8;
    localparam int HIW = SW - 2 * FB;

    localparam logic [TW-1:0]    ONE_T   = TW'(1) << FB;
    localparam logic [TW-1:0]    THREE_T = TW'(3) << FB;
    localparam logic [TW-1:0]    FOUR_T  = TW'(4) << FB;
    localparam logic [HIW-1:0]   MAX_HI  = HIW'({OUT_W{1'b1}});

    arm_t            arm_c;
    logic [XW-1:0]   x_c;
    logic [PW-1:0]   val_c;
    logic [SW-1:0]   sc;
    logic [HIW-1:0]  hi;

    arm_t            arm2_reg;
    logic [XW-1:0]   x2_reg;
    arm_t            arm3_reg;
    logic [PW-1:0]   prod3_reg;
    logic [VW-1:0]   base3_reg;
    logic [PW-1:0]   val4_reg;
    logic [OUT_W-1:0] level5_reg;

    always_comb begin
        priority if (t < ONE_T) begin
            arm_c = ARM_RISE;
            x_c   = t[XW-1:0];
        end else if (t < THREE_T) begin
            arm_c = ARM_HIGH;
            x_c   = '0;
        end else if (t < FOUR_T) begin
            arm_c = ARM_FALL;
            x_c   = XW'(FOUR_T - t);
        end else begin
            arm_c = ARM_LOW;
            x_c   = '0;
        end
    end

    always_comb begin
        unique case (arm3_reg)
            ARM_RISE, ARM_FALL: val_c = (PW'(base3_reg) << FB) + prod3_reg;
            ARM_HIGH, ARM_LOW:  val_c = PW'(base3_reg) << FB;
            default:            val_c = PW'(base3_reg) << FB;
        endcase
    end

    always_comb begin
        sc = (SW'(val4_reg) << 8) - SW'(val4_reg);
        hi = sc[SW-1:2*FB];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            arm2_reg   <= arm_c;
            x2_reg     <= x_c;
            arm3_reg   <= arm2_reg;
            prod3_reg  <= PW'(d) * PW'(x2_reg);
            base3_reg  <= (arm2_reg == ARM_HIGH) ? q : p;
            val4_reg   <= val_c;
            level5_reg <= (hi > MAX_HI) ? {OUT_W{1'b1}} : hi[OUT_W-1:0];
        end
    end

    assign level_q = level5_reg;

endmodule

[rtl/hsl_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to 8-bit RGB color conversion, five register stages.
// ----------------------------------------------------------------------------
// The converter takes one request per clock unless a result waits on a
// stalled output. Each result passes the five register stages and is held
// on the m_ ports until taken. Results come out in request order.
// The five stages are: clamp and lightness by saturation multiply, q/p forming
// and ramp segment select, one slope multiply per channel, base add, and the
// 255 scale with clamp. A stalled output holds the whole pipeline, so s_ready
// follows m_ready whenever a result is waiting. FRACTION_BITS sets the input
// fraction format; the input ports stay 16 bits wide.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
    parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [hsl_pkg::IN_W-1:0]  s_hue,
    input  logic [hsl_pkg::IN_W-1:0]  s_saturation,
    input  logic [hsl_pkg::IN_W-1:0]  s_lightness,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [hsl_pkg::OUT_W-1:0] m_red,
    output logic [hsl_pkg::OUT_W-1:0] m_green,
    output logic [hsl_pkg::OUT_W-1:0] m_blue
);
    import hsl_pkg::*;

    localparam int FB   = FRACTION_BITS;
    localparam int NSTG = 5;

    logic                adv;
    logic [NSTG-1:0]     vld_reg;
    logic [NSTG-1:0]     vld_next;

    logic [FB:0]         l1;
    logic [FB:0]         s1;
    logic [2*FB+1:0]     prod1;
    logic [FB+2:0]       t_r1;
    logic [FB+2:0]       t_g1;
    logic [FB+2:0]       t_b1;
    logic [FB:0]         p2;
    logic [FB:0]         q2;
    logic [FB:0]         d2;

    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTG-1];

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[NSTG-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    hsl_front #(.FB(FB)) u_front (
        .aclk       (aclk),
        .adv        (adv),
        .hue        (s_hue),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .l_q        (l1),
        .s_q        (s1),
        .prod_q     (prod1),
        .t_r_q      (t_r1),
        .t_g_q      (t_g1),
        .t_b_q      (t_b1)
    );

    hsl_pq #(.FB(FB)) u_pq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .vld     (vld_reg[1]),
        .l       (l1),
        .s       (s1),
        .prod    (prod1),
        .p_q     (p2),
        .q_q     (q2),
        .d_q     (d2)
    );

    hsl_chan #(.FB(FB)) u_chan_red (
        .aclk    (aclk),
        .adv     (adv),
        .t       (t_r1),
        .p       (p2),
        .q       (q2),
        .d       (d2),
        .level_q (m_red)
    );

    hsl_chan #(.FB(FB)) u_chan_green (
        .aclk    (aclk),
        .adv     (adv),
        .t       (t_g1),
        .p       (p2),
        .q       (q2),
        .d       (d2),
        .level_q (m_green)
    );

    hsl_chan #(.FB(FB)) u_chan_blue (
        .aclk    (aclk),
        .adv     (adv),
        .t       (t_b1),
        .p       (p2),
        .q       (q2),
        .d       (d2),
        .level_q (m_blue)
    );

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request missing from first stage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !vld_reg[NSTG-2] |=> !m_valid)
        else $error("result repeated after delivery");

endmodule
